// ===== rtl/core/etr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_pkg
// Shared types and constants for the event trace ring with replay.
// ----------------------------------------------------------------------------
package etr_pkg;

    // storage sizes (depths are powers of two, the ring pointers wrap by mask)
    localparam int HIST_DEPTH   = 256;
    localparam int PEND_DEPTH   = 256;
    localparam int PAYLOAD_BITS = 32;

    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
    localparam int PEND_AW = $clog2(PEND_DEPTH);
    localparam int PEND_CW = $clog2(PEND_DEPTH + 1);

    localparam int SECS_W  = 32;
    localparam int ENTRY_W = SECS_W + PAYLOAD_BITS;

    // configuration register widths and reset values
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HCAP_W     = 16;
    localparam int CAP_W      = 9;
    localparam logic [HCAP_W-1:0] HCAP_RESET = 16'd300;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd256;

    // stream widths
    localparam int CMD_W      = 3;
    localparam int SID_W      = 8;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HORIZON_CAP = 2'd0,
        CFG_HIST_CAP    = 2'd1,
        CFG_PEND_CAP    = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_OBSERVE = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_DETACH  = 3'd3,
        CMD_RESET   = 3'd4,
        CMD_POP     = 3'd5,
        CMD_TAKE    = 3'd6,
        CMD_QUERY   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_REPL_RD,
        ST_REPL_WR
    } t_state;

    typedef struct packed {
        logic        accepted;
        logic [15:0] eff_horizon;
        logic [8:0]  eff_min_count;
        logic        event_valid;
        logic [31:0] secs;
        logic [31:0] payload;
        logic [31:0] dropped;
    } t_result;

endpackage

// ===== rtl/core/etr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module etr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_rd,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/core/event_trace_ring_with_replay_top.sv =====
`timescale 1ns / 1ps
// Observe, stop, detach, reset all, take drops, query, a rejected start or pop: result is
// registered at accept. Pop: the pending RAM read is issued at accept, ST_POP registers it.
// Start: each history entry scanned for the horizon passes ST_SCAN_RD and ST_SCAN_CHK, each
// replayed entry ST_REPL_RD and ST_REPL_WR, then a last ST_REPL_RD finishes; the scan ends where
// replay begins. One transaction in flight; a new one is taken once the result is taken.
// Synchronous active-low reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
// event_trace_ring_with_replay_top
// History ring of timestamped events with a subscriber replay FIFO.
// ----------------------------------------------------------------------------
module event_trace_ring_with_replay_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [etr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [etr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // session_id[7:0], event_seconds[39:8], event_payload[71:40],
    // now_seconds[103:72], requested_horizon[119:104], requested_min_count[128:120]
    input  logic [etr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [etr_pkg::CMD_W-1:0]      s_axis_tuser,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // accepted[0], effective_horizon[16:1], effective_min_count[25:17],
    // event_valid[26], out_event_seconds[58:27], out_event_payload[90:59],
    // dropped_count[122:91]
    output logic [etr_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import etr_pkg::*;

    // registers
    t_state              r_state, n_state;
    logic [HIST_AW-1:0]  r_hist_head, n_hist_head;
    logic [HIST_CW-1:0]  r_hist_cnt, n_hist_cnt;
    logic [PEND_AW-1:0]  r_pend_head, n_pend_head;
    logic [PEND_CW-1:0]  r_pend_cnt, n_pend_cnt;
    logic [31:0]         r_drops, n_drops;
    logic [SID_W-1:0]    r_owner_id, n_owner_id;
    logic                r_owner, n_owner;
    logic                r_sub, n_sub;
    logic [HCAP_W-1:0]   r_cap_h;
    logic [CAP_W-1:0]    r_cap_hist, r_cap_pend;
    logic [15:0]         r_h, n_h;
    logic [31:0]         r_now, n_now;
    logic [HIST_CW-1:0]  r_idx, n_idx;
    logic [HIST_CW-1:0]  r_bycnt, n_bycnt;
    t_result             r_res, n_res;
    logic                r_out_valid, n_out_valid;

    // input fields
    t_cmd                in_cmd;
    logic [SID_W-1:0]    in_sid;
    logic [31:0]         in_secs, in_payload, in_now;
    logic [15:0]         in_req_h;
    logic [8:0]          in_req_m;
    logic                in_acc;

    assign in_cmd     = t_cmd'(s_axis_tuser);
    assign in_sid     = s_axis_tdata[7:0];
    assign in_secs    = s_axis_tdata[39:8];
    assign in_payload = s_axis_tdata[71:40];
    assign in_now     = s_axis_tdata[103:72];
    assign in_req_h   = s_axis_tdata[119:104];
    assign in_req_m   = s_axis_tdata[128:120];
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    // ram signals
    logic                hist_we, hist_rd, pend_we, pend_rd;
    logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
    logic [PEND_AW-1:0]  pend_waddr, pend_raddr;
    logic [ENTRY_W-1:0]  hist_wdata, hist_rdata, pend_wdata, pend_rdata;
    logic [ENTRY_W-1:0]  in_entry;

    assign in_entry = {in_payload[PAYLOAD_BITS-1:0], in_secs};

    etr_ram #(.DEPTH(HIST_DEPTH), .WIDTH(ENTRY_W)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_rd    (hist_rd),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    etr_ram #(.DEPTH(PEND_DEPTH), .WIDTH(ENTRY_W)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_rd    (pend_rd),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    // effective capacities
    logic [HIST_CW-1:0] hist_cap;
    logic [PEND_CW-1:0] pend_cap;

    always_comb begin
        if (int'(r_cap_hist) > HIST_DEPTH) hist_cap = HIST_CW'(HIST_DEPTH);
        else                               hist_cap = HIST_CW'(r_cap_hist);
        if (int'(r_cap_pend) > PEND_DEPTH) pend_cap = PEND_CW'(PEND_DEPTH);
        else                               pend_cap = PEND_CW'(r_cap_pend);
    end

    // history push: slot address and trimmed head and count
    logic               hp_full;
    logic [HIST_AW-1:0] hp_head1, hp_head, hp_waddr;
    logic [HIST_CW-1:0] hp_cnt1, hp_cnt2, hp_cnt, hp_trim;

    always_comb begin
        hp_full  = (int'(r_hist_cnt) >= HIST_DEPTH);
        hp_head1 = hp_full ? r_hist_head + 1'b1 : r_hist_head;
        hp_cnt1  = hp_full ? r_hist_cnt - 1'b1 : r_hist_cnt;
        hp_waddr = hp_head1 + hp_cnt1[HIST_AW-1:0];
        hp_cnt2  = hp_cnt1 + 1'b1;
        hp_trim  = '0;
        if (hp_cnt2 > hist_cap) hp_trim = hp_cnt2 - hist_cap;
        hp_head  = hp_head1 + hp_trim[HIST_AW-1:0];
        hp_cnt   = hp_cnt2 - hp_trim;
    end

    // pending push unit, shared by observe and replay, counts drops
    logic               pp_full;
    logic [PEND_AW-1:0] pp_head1, pp_head, pp_waddr;
    logic [PEND_CW-1:0] pp_cnt1, pp_cnt2, pp_cnt, pp_trim;
    logic [32:0]        pp_sum;
    logic [31:0]        pp_drops;

    always_comb begin
        pp_full  = (int'(r_pend_cnt) >= PEND_DEPTH);
        pp_head1 = pp_full ? r_pend_head + 1'b1 : r_pend_head;
        pp_cnt1  = pp_full ? r_pend_cnt - 1'b1 : r_pend_cnt;
        pp_waddr = pp_head1 + pp_cnt1[PEND_AW-1:0];
        pp_cnt2  = pp_cnt1 + 1'b1;
        pp_trim  = '0;
        if (pp_cnt2 > pend_cap) pp_trim = pp_cnt2 - pend_cap;
        pp_head  = pp_head1 + pp_trim[PEND_AW-1:0];
        pp_cnt   = pp_cnt2 - pp_trim;
        pp_sum   = {1'b0, r_drops} + 33'(pp_trim) + 33'(pp_full);
        pp_drops = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
    end

    // start clamps and by-count point
    logic [15:0]        st_h;
    logic [8:0]         st_m;
    logic [HIST_CW-1:0] st_bycnt;
    logic               is_owner;

    always_comb begin
        st_h = (in_req_h < r_cap_h) ? in_req_h : r_cap_h;
        st_m = (in_req_m < r_cap_hist) ? in_req_m : r_cap_hist;
        if (st_m == '0)                          st_bycnt = r_hist_cnt;
        else if (int'(st_m) >= int'(r_hist_cnt)) st_bycnt = '0;
        else                                     st_bycnt = r_hist_cnt - HIST_CW'(st_m);
        is_owner = r_owner && (r_owner_id == in_sid);
    end

    // horizon compare on the scanned entry
    logic [32:0] hz_delta;
    logic        hz_inside;
    logic [HIST_CW-1:0] idx_inc;

    always_comb begin
        hz_delta  = {1'b0, r_now} - {1'b0, hist_rdata[SECS_W-1:0]};
        hz_inside = hz_delta[32] || (hz_delta[31:0] < {16'b0, r_h});
        idx_inc   = r_idx + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == CMD_POP && is_owner && r_pend_cnt != '0) begin
                        n_state = ST_POP;
                    end else if (in_cmd == CMD_START && !(r_owner && !is_owner)) begin
                        if (st_h != '0 && st_bycnt != '0) n_state = ST_SCAN_RD;
                        else                              n_state = ST_REPL_RD;
                    end
                end
            end
            ST_POP:      n_state = ST_IDLE;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (hz_inside || idx_inc == r_bycnt) n_state = ST_REPL_RD;
                else                                 n_state = ST_SCAN_RD;
            end
            ST_REPL_RD: begin
                if (r_idx == r_hist_cnt) n_state = ST_IDLE;
                else                     n_state = ST_REPL_WR;
            end
            ST_REPL_WR:  n_state = ST_REPL_RD;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs: handshake and ram control
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
        hist_we    = 1'b0;
        hist_waddr = hp_waddr;
        hist_wdata = in_entry;
        hist_rd    = 1'b0;
        hist_raddr = r_hist_head + r_idx[HIST_AW-1:0];
        pend_we    = 1'b0;
        pend_waddr = pp_waddr;
        pend_wdata = in_entry;
        pend_rd    = 1'b0;
        pend_raddr = r_pend_head;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_cmd == CMD_OBSERVE) begin
                    hist_we = 1'b1;
                    pend_we = r_sub;
                end
                if (in_acc && in_cmd == CMD_POP) pend_rd = 1'b1;
            end
            ST_SCAN_RD, ST_REPL_RD: hist_rd = 1'b1;
            ST_REPL_WR: begin
                pend_we    = 1'b1;
                pend_wdata = hist_rdata;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_hist_head = r_hist_head;
        n_hist_cnt  = r_hist_cnt;
        n_pend_head = r_pend_head;
        n_pend_cnt  = r_pend_cnt;
        n_drops     = r_drops;
        n_owner_id  = r_owner_id;
        n_owner     = r_owner;
        n_sub       = r_sub;
        n_h         = r_h;
        n_now       = r_now;
        n_idx       = r_idx;
        n_bycnt     = r_bycnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        if (m_axis_tvalid && m_axis_tready) n_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res       = '0;
                    n_out_valid = 1'b1;
                    unique case (in_cmd)
                        CMD_OBSERVE: begin
                            n_hist_head = hp_head;
                            n_hist_cnt  = hp_cnt;
                            if (r_sub) begin
                                n_pend_head = pp_head;
                                n_pend_cnt  = pp_cnt;
                                n_drops     = pp_drops;
                            end
                        end
                        CMD_START: begin
                            n_res.eff_horizon   = st_h;
                            n_res.eff_min_count = st_m;
                            if (!(r_owner && !is_owner)) begin
                                n_res.accepted = 1'b1;
                                n_out_valid    = 1'b0;
                                n_owner        = 1'b1;
                                n_owner_id     = in_sid;
                                n_sub          = 1'b1;
                                n_pend_head    = '0;
                                n_pend_cnt     = '0;
                                n_drops        = '0;
                                n_h            = st_h;
                                n_now          = in_now;
                                n_bycnt        = st_bycnt;
                                if (st_h != '0 && st_bycnt != '0) n_idx = '0;
                                else                              n_idx = st_bycnt;
                            end
                        end
                        CMD_STOP, CMD_DETACH, CMD_RESET: begin
                            if (is_owner || in_cmd == CMD_RESET) begin
                                n_owner     = 1'b0;
                                n_owner_id  = '0;
                                n_sub       = 1'b0;
                                n_pend_head = '0;
                                n_pend_cnt  = '0;
                                n_drops     = '0;
                                if (in_cmd != CMD_DETACH) begin
                                    n_hist_head = '0;
                                    n_hist_cnt  = '0;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (is_owner && r_pend_cnt != '0) begin
                                n_out_valid = 1'b0;
                                n_pend_head = r_pend_head + 1'b1;
                                n_pend_cnt  = r_pend_cnt - 1'b1;
                            end
                        end
                        CMD_TAKE: begin
                            n_res.dropped = r_drops;
                            n_drops       = '0;
                        end
                        CMD_QUERY: n_res.accepted = is_owner && r_sub;
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                n_res.event_valid = 1'b1;
                n_res.secs        = pend_rdata[SECS_W-1:0];
                n_res.payload     = 32'(pend_rdata[ENTRY_W-1:SECS_W]);
                n_out_valid       = 1'b1;
            end
            ST_SCAN_CHK: begin
                if (!hz_inside) n_idx = idx_inc;
            end
            ST_REPL_RD: begin
                if (r_idx == r_hist_cnt) n_out_valid = 1'b1;
            end
            ST_REPL_WR: begin
                n_pend_head = pp_head;
                n_pend_cnt  = pp_cnt;
                n_drops     = pp_drops;
                n_idx       = idx_inc;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hist_head <= '0;
            r_hist_cnt  <= '0;
            r_pend_head <= '0;
            r_pend_cnt  <= '0;
            r_drops     <= '0;
            r_owner_id  <= '0;
            r_owner     <= 1'b0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hist_head <= n_hist_head;
            r_hist_cnt  <= n_hist_cnt;
            r_pend_head <= n_pend_head;
            r_pend_cnt  <= n_pend_cnt;
            r_drops     <= n_drops;
            r_owner_id  <= n_owner_id;
            r_owner     <= n_owner;
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_h    <= HCAP_RESET;
            r_cap_hist <= CAP_RESET;
            r_cap_pend <= CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HORIZON_CAP: r_cap_h    <= i_cfg_data;
                CFG_HIST_CAP:    r_cap_hist <= i_cfg_data[CAP_W-1:0];
                CFG_PEND_CAP:    r_cap_pend <= i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_now   <= n_now;
        r_idx   <= n_idx;
        r_bycnt <= n_bycnt;
        r_res   <= n_res;
    end

    // result packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_res.dropped, r_res.payload, r_res.secs,
                            r_res.event_valid, r_res.eff_min_count,
                            r_res.eff_horizon, r_res.accepted};
endmodule

// ===== rtl/core/etr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_checker
// Port-level checks for the event trace ring, bound to the top level.
// ----------------------------------------------------------------------------
module etr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [etr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import etr_pkg::*;

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one transaction at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    // no input taken while a result waits
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
endmodule

bind event_trace_ring_with_replay_top etr_checker u_etr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the trace ring, predicts each result with a local
// model of ring, pending queue, ownership and drops, and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import etr_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    event_trace_ring_with_replay_top DUT (.*);

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  sid;
        logic [31:0] ev_secs;
        logic [31:0] ev_data;
        logic [31:0] now;
        logic [15:0] req_h;
        logic [8:0]  req_m;
    } t_cmd_item;

    typedef struct {
        t_cmd_item it;
        bit        known;
        t_result   want;
    } t_row;

    // model state
    logic [31:0] ring_secs [HIST_DEPTH];
    logic [31:0] ring_data [HIST_DEPTH];
    int unsigned ring_head, ring_cnt;
    logic [31:0] fifo_secs [PEND_DEPTH];
    logic [31:0] fifo_data [PEND_DEPTH];
    int unsigned fifo_head, fifo_cnt;
    logic [31:0] drops;
    logic [7:0]  owner;
    bit          owned, subscribed;
    int unsigned cap_horizon, cap_hist, cap_pend;

    // expected results in order of acceptance
    t_result     due_buf [1024];
    int unsigned due_wr, due_rd;
    // directed stimulus table
    t_row        rows [32];
    int          n_rows;
    int          mismatches;
    bit          timed_out;
    bit          rand_gap;

    function automatic void bump_drops();
        if (drops != 32'hFFFF_FFFF) drops++;
    endfunction

    function automatic void ring_push(logic [31:0] s, logic [31:0] d);
        int unsigned cap;
        cap = cap_hist > HIST_DEPTH ? HIST_DEPTH : cap_hist;
        if (ring_cnt >= HIST_DEPTH) begin
            ring_head = (ring_head + 1) % HIST_DEPTH;
            ring_cnt--;
        end
        ring_secs[(ring_head + ring_cnt) % HIST_DEPTH] = s;
        ring_data[(ring_head + ring_cnt) % HIST_DEPTH] = d;
        ring_cnt++;
        while (ring_cnt > cap) begin
            ring_head = (ring_head + 1) % HIST_DEPTH;
            ring_cnt--;
        end
    endfunction

    function automatic void fifo_push(logic [31:0] s, logic [31:0] d);
        int unsigned cap;
        cap = cap_pend > PEND_DEPTH ? PEND_DEPTH : cap_pend;
        if (fifo_cnt >= PEND_DEPTH) begin
            fifo_head = (fifo_head + 1) % PEND_DEPTH;
            fifo_cnt--;
            bump_drops();
        end
        fifo_secs[(fifo_head + fifo_cnt) % PEND_DEPTH] = s;
        fifo_data[(fifo_head + fifo_cnt) % PEND_DEPTH] = d;
        fifo_cnt++;
        while (fifo_cnt > cap) begin
            fifo_head = (fifo_head + 1) % PEND_DEPTH;
            fifo_cnt--;
            bump_drops();
        end
    endfunction

    function automatic void drop_owner();
        owned = 0; owner = 0; subscribed = 0;
        fifo_head = 0; fifo_cnt = 0; drops = 0;
    endfunction

    function automatic void trace_reset();
        ring_head = 0; ring_cnt = 0;
        drop_owner();
        cap_horizon = 300; cap_hist = 256; cap_pend = 256;
    endfunction

    // first ring index to replay: earlier of horizon hit and min-count window
    function automatic int unsigned replay_from(logic [31:0] now, int unsigned h,
                                                int unsigned m);
        int unsigned by_cnt, by_time;
        longint delta;
        by_time = ring_cnt;
        if (m == 0) by_cnt = ring_cnt;
        else if (m >= ring_cnt) by_cnt = 0;
        else by_cnt = ring_cnt - m;
        if (h != 0) begin
            for (int unsigned i = 0; i < ring_cnt; i++) begin
                delta = longint'(now) - longint'(ring_secs[(ring_head + i) % HIST_DEPTH]);
                if (delta < longint'(h)) begin
                    by_time = i;
                    break;
                end
            end
        end
        return by_cnt < by_time ? by_cnt : by_time;
    endfunction

    function automatic t_result trace_step(t_cmd_item it);
        t_result r;
        int unsigned h, m, j;
        bit mine;
        r = '0;
        mine = owned && owner == it.sid;
        case (it.cmd)
            CMD_OBSERVE: begin
                ring_push(it.ev_secs, it.ev_data);
                if (subscribed) fifo_push(it.ev_secs, it.ev_data);
            end
            CMD_START: begin
                h = it.req_h < cap_horizon ? it.req_h : cap_horizon;
                m = it.req_m < cap_hist ? it.req_m : cap_hist;
                r.eff_horizon = 16'(h);
                r.eff_min_count = 9'(m);
                if (!(owned && owner != it.sid)) begin
                    owned = 1; owner = it.sid;
                    fifo_head = 0; fifo_cnt = 0; drops = 0;
                    subscribed = 1;
                    j = replay_from(it.now, h, m);
                    for (int unsigned i = j; i < ring_cnt; i++)
                        fifo_push(ring_secs[(ring_head + i) % HIST_DEPTH],
                                  ring_data[(ring_head + i) % HIST_DEPTH]);
                    r.accepted = 1;
                end
            end
            CMD_STOP: if (mine) begin
                drop_owner();
                ring_head = 0; ring_cnt = 0;
            end
            CMD_DETACH: if (mine) drop_owner();
            CMD_RESET: begin
                drop_owner();
                ring_head = 0; ring_cnt = 0;
            end
            CMD_POP: if (mine && fifo_cnt != 0) begin
                r.event_valid = 1;
                r.secs = fifo_secs[fifo_head];
                r.payload = fifo_data[fifo_head];
                fifo_head = (fifo_head + 1) % PEND_DEPTH;
                fifo_cnt--;
            end
            CMD_TAKE: begin
                r.dropped = drops;
                drops = 0;
            end
            default: r.accepted = mine && subscribed;
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // idle draw: none during the quiet stretch
    function automatic bit idle_now();
        return rand_gap && ($urandom_range(99) < 31);
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.accepted      = m_axis_tdata[0];
            got.eff_horizon   = m_axis_tdata[16:1];
            got.eff_min_count = m_axis_tdata[25:17];
            got.event_valid   = m_axis_tdata[26];
            got.secs          = m_axis_tdata[58:27];
            got.payload       = m_axis_tdata[90:59];
            got.dropped       = m_axis_tdata[122:91];
            if (due_wr == due_rd) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = due_buf[due_rd % 1024];
                due_rd++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !idle_now();
    end

    task automatic cfg_write(t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_HORIZON_CAP: cap_horizon = val & 16'hFFFF;
            CFG_HIST_CAP:    cap_hist = val & 9'h1FF;
            CFG_PEND_CAP:    cap_pend = val & 9'h1FF;
            default: ;
        endcase
    endtask

    // send one transaction; prediction made at acceptance
    task automatic send_cmd(t_cmd_item it, bit has_want, t_result want);
        t_result r;
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {7'd0, it.req_m, it.req_h, it.now, it.ev_data,
                          it.ev_secs, it.sid};
        do @(posedge i_clk); while (!s_axis_tready);
        r = trace_step(it);
        if (has_want && r !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row: expected %h predicted %h", want, r);
        end
        due_buf[due_wr % 1024] = r;
        due_wr++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_wr != due_rd) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    function automatic t_cmd_item mk(t_cmd c, logic [7:0] sid, logic [31:0] es,
                                     logic [31:0] ed, logic [31:0] now,
                                     logic [15:0] h, logic [8:0] m);
        t_cmd_item it;
        it.cmd = c; it.sid = sid; it.ev_secs = es; it.ev_data = ed;
        it.now = now; it.req_h = h; it.req_m = m;
        return it;
    endfunction

    function automatic void add_row(t_cmd_item it, bit known, t_result want);
        rows[n_rows].it    = it;
        rows[n_rows].known = known;
        rows[n_rows].want  = want;
        n_rows++;
    endfunction

    // random item; mostly owner traffic to stay deep in subscribed states
    function automatic t_cmd_item rand_item(logic [7:0] sess);
        t_cmd_item it;
        int unsigned p;
        logic [31:0] base;
        base = 32'd1000;
        it = mk(CMD_OBSERVE, $urandom_range(9) < 8 ? sess : 8'($urandom),
                $urandom_range(3) == 0 ? $urandom : base - $urandom_range(400),
                $urandom, $urandom_range(3) == 0 ? $urandom : base,
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(600)),
                $urandom_range(3) == 0 ? 9'($urandom) : 9'($urandom_range(40)));
        p = $urandom_range(99);
        if (p < 45) it.cmd = CMD_OBSERVE;
        else if (p < 72) it.cmd = CMD_POP;
        else if (p < 80) it.cmd = CMD_START;
        else if (p < 84) it.cmd = CMD_STOP;
        else if (p < 88) it.cmd = CMD_DETACH;
        else if (p < 90) it.cmd = CMD_RESET;
        else if (p < 95) it.cmd = CMD_TAKE;
        else it.cmd = CMD_QUERY;
        return it;
    endfunction

    initial begin
        t_result z, w;
        logic [7:0] sess;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = CFG_HORIZON_CAP; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = CMD_OBSERVE;
        mismatches = 0; timed_out = 0; rand_gap = 1;
        due_wr = 0; due_rd = 0; n_rows = 0;
        trace_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        z = '0;
        w = '0; w.eff_horizon = 300; w.eff_min_count = 256; w.accepted = 1;
        add_row(mk(CMD_QUERY, 8'h00, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_POP, 8'h00, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_OBSERVE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0), 1, z);
        add_row(mk(CMD_OBSERVE, 0, 32'h0, 32'h0, 0, 0, 0), 1, z);
        add_row(mk(CMD_OBSERVE, 0, 32'd50, 32'hA5A5_5A5A, 0, 0, 0), 1, z);
        add_row(mk(CMD_START, 8'hFF, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 9'h1FF), 1, w);
        add_row(mk(CMD_START, 8'h01, 0, 0, 0, 10, 2), 0, z);
        add_row(mk(CMD_QUERY, 8'hFF, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_POP, 8'h01, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_POP, 8'hFF, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_POP, 8'hFF, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_OBSERVE, 0, 32'd70, 32'd7, 0, 0, 0), 0, z);
        add_row(mk(CMD_DETACH, 8'hFF, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_START, 8'h02, 0, 0, 32'd100, 16'd60, 9'd0), 0, z);
        add_row(mk(CMD_START, 8'h02, 0, 0, 32'd100, 16'd0, 9'd1), 0, z);
        add_row(mk(CMD_TAKE, 8'h33, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_STOP, 8'h09, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_STOP, 8'h02, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_RESET, 8'h00, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_QUERY, 8'h02, 0, 0, 0, 0, 0), 1, z);
        for (int k = 0; k < n_rows; k++) send_cmd(rows[k].it, rows[k].known, rows[k].want);
        drain();

        // capacity zero: every queued event is dropped
        cfg_write(CFG_HIST_CAP, 0);
        cfg_write(CFG_PEND_CAP, 0);
        cfg_write(CFG_HORIZON_CAP, 16'hFFFF);
        send_cmd(mk(CMD_START, 8'h05, 0, 0, 0, 16'hFFFF, 9'h1FF), 0, z);
        for (int k = 0; k < 6; k++)
            send_cmd(mk(CMD_OBSERVE, 0, k, k, 0, 0, 0), 0, z);
        send_cmd(mk(CMD_POP, 8'h05, 0, 0, 0, 0, 0), 0, z);
        send_cmd(mk(CMD_TAKE, 8'h05, 0, 0, 0, 0, 0), 0, z);
        send_cmd(mk(CMD_RESET, 0, 0, 0, 0, 0, 0), 0, z);
        drain();

        // random phases over several settings, one without idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_HIST_CAP, 256); cfg_write(CFG_PEND_CAP, 256);
                          cfg_write(CFG_HORIZON_CAP, 300); end
                1: begin cfg_write(CFG_HIST_CAP, 12); cfg_write(CFG_PEND_CAP, 5);
                          cfg_write(CFG_HORIZON_CAP, 0); end
                2: begin cfg_write(CFG_HIST_CAP, 511); cfg_write(CFG_PEND_CAP, 3);
                          cfg_write(CFG_HORIZON_CAP, 16'hFFFF); rand_gap = 0; end
                3: begin cfg_write(CFG_HIST_CAP, 30); cfg_write(CFG_PEND_CAP, 511);
                          cfg_write(CFG_HORIZON_CAP, 150); rand_gap = 1; end
                default: begin cfg_write(CFG_HIST_CAP, 1); cfg_write(CFG_PEND_CAP, 1);
                          cfg_write(CFG_HORIZON_CAP, 20); end
            endcase
            sess = 8'($urandom);
            for (int k = 0; k < 150; k++)
                send_cmd(rand_item(sess), 0, z);
            drain();
            // a lowered capacity trims on the next push; the ring keeps its layout
        end

        if (mismatches == 0 && !timed_out)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        timed_out = 1;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/etr_pkg.sv
rtl/core/etr_ram.sv
rtl/core/event_trace_ring_with_replay_top.sv
rtl/core/etr_checker.sv
verif/tb_top.sv
